FILE: rtl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// Item layouts, operation codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

    localparam int MAX_DIM_DEF    = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int ROW_W   = 4;
    localparam int COL_W   = 4;
    localparam int DATA_W  = 32;
    localparam int DIM_W   = 5;
    localparam int CFG_IDX_W = 8;
    localparam int MAX_RESULTS = 16;

    // operation codes
    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 8'd2;

    typedef struct packed {
        logic [1:0]              operation;
        logic [ROW_W-1:0]        row_index;
        logic [COL_W-1:0]        col_index;
        logic signed [DATA_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]         out_row;
        logic [COL_W-1:0]         out_col;
        logic signed [DATA_W-1:0] product_value;
        logic                     saturated;
        logic                     row_error;
        logic                     last_of_row;
    } t_out_item;

    // one memory read issued toward the multiply-accumulate unit
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctrl;

endpackage

`default_nettype wire

FILE: rtl/mme_store.sv
// ----------------------------------------------------------------------------
// mme_store: element memories for matrices A and B
// One write port shared by both arrays, one registered read port on each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mme_store #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF,
    parameter int ELEM_W  = mme_pkg::DATA_W,
    localparam int DEPTH  = MAX_DIM * MAX_DIM,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic                     i_wr_sel_b,
    input  wire logic [ADDR_W-1:0]        i_wr_addr,
    input  wire logic signed [ELEM_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0]        i_rd_addr_a,
    input  wire logic [ADDR_W-1:0]        i_rd_addr_b,
    output logic signed [ELEM_W-1:0]      o_rd_data_a,
    output logic signed [ELEM_W-1:0]      o_rd_data_b
);

    logic signed [ELEM_W-1:0] r_a_mem [DEPTH];
    logic signed [ELEM_W-1:0] r_b_mem [DEPTH];
    logic signed [ELEM_W-1:0] r_rd_a;
    logic signed [ELEM_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_wr_sel_b) begin
            r_a_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_a_mem[i_rd_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_sel_b) begin
            r_b_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_b <= r_b_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

FILE: rtl/mme_mac.sv
// ----------------------------------------------------------------------------
// mme_mac: multiply-accumulate unit with rounding and saturation
// Product register, exact wide accumulator, round to Q16.16 and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mme_mac #(
    parameter int ELEM_W = mme_pkg::DATA_W,
    localparam int PROD_W = 2 * ELEM_W,
    localparam int ACC_W  = PROD_W + 5
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire mme_pkg::t_mac_ctrl       i_ctrl,
    input  wire logic signed [ELEM_W-1:0] i_a,
    input  wire logic signed [ELEM_W-1:0] i_b,
    input  wire logic                     i_take,
    output logic                          o_done,
    output logic signed [mme_pkg::DATA_W-1:0] o_value,
    output logic                          o_sat
);

    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W-16){1'b0}}, 1'b1, 15'b0};
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-ELEM_W+1){1'b1}}, {(ELEM_W-1){1'b0}}};

    mme_pkg::t_mac_ctrl       r_c1;
    mme_pkg::t_mac_ctrl       r_c2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     r_done;
    logic                     n_done;

    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ELEM_W-1:0] w_val;
    logic                     w_hi;
    logic                     w_lo;

    // control follows the memory read latency, then the product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1   <= '0;
            r_c2   <= '0;
            r_done <= 1'b0;
        end else begin
            r_c1   <= i_ctrl;
            r_c2   <= r_c1;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        r_acc  <= n_acc;
    end

    always_comb begin
        n_acc  = r_acc;
        n_done = r_done;
        if (r_c2.valid) begin
            if (r_c2.first) begin
                n_acc = ACC_W'(r_prod);
            end else begin
                n_acc = r_acc + ACC_W'(r_prod);
            end
            if (r_c2.last) begin
                n_done = 1'b1;
            end
        end else if (i_take) begin
            n_done = 1'b0;
        end
    end

    // round to nearest with ties up, then clamp to the element range
    assign w_rnd = (r_acc + RND_HALF) >>> 16;
    assign w_hi  = w_rnd > SAT_MAX;
    assign w_lo  = w_rnd < SAT_MIN;

    always_comb begin
        priority if (w_hi) begin
            w_val = SAT_MAX[ELEM_W-1:0];
        end else if (w_lo) begin
            w_val = SAT_MIN[ELEM_W-1:0];
        end else begin
            w_val = w_rnd[ELEM_W-1:0];
        end
    end

    assign o_done  = r_done;
    assign o_value = mme_pkg::DATA_W'(w_val);
    assign o_sat   = w_hi || w_lo;

endmodule

`default_nettype wire

FILE: rtl/matrix_multiply_engine_top.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top: row-at-a-time matrix multiply over two memories
// Load items fill A and B; a compute item streams one row of the product.
// ----------------------------------------------------------------------------
// load item: taken while idle; operation 3 is also taken and gives nothing
// compute item: each product element takes one memory read pair per inner step, then
// passes the read, product and accumulate registers; the next item is taken once the
// last result of the row has been loaded into the output register
// a row error item skips the memory reads and gives its single result from the emit state
// reset clears control and sets the dimension registers to 16; memories are not cleared
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_engine_top #(
    parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
    parameter int VALUE_BITS = mme_pkg::VALUE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire mme_pkg::t_in_item                i_in_item,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output mme_pkg::t_out_item                    o_out_item,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [mme_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mme_pkg::DIM_W-1:0]        i_cfg_data
);

    localparam int ELEM_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int DIM_W  = mme_pkg::DIM_W;
    localparam int ROW_W  = mme_pkg::ROW_W;
    localparam int COL_W  = mme_pkg::COL_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MAC  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [DIM_W-1:0]   r_rows_a, r_inner_dim, r_cols_b;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_j, n_j;
    logic [COL_W-1:0]   r_n_last, n_n_last;
    logic [DIM_W-1:0]   r_k, n_k;
    logic [DIM_W-1:0]   r_l_last, n_l_last;
    logic [ADDR_W-1:0]  r_a_base, n_a_base;
    logic [ADDR_W-1:0]  r_a_addr, n_a_addr;
    logic [ADDR_W-1:0]  r_b_addr, n_b_addr;
    logic               r_err, n_err;
    logic               r_out_valid, n_out_valid;
    mme_pkg::t_out_item r_out, n_out;

    logic               w_in_accept;
    logic               w_is_load;
    logic               w_ld_in_range;
    logic               w_wr_en;
    logic [ADDR_W-1:0]  w_ld_addr;
    logic [DIM_W-1:0]   w_m, w_l, w_n, w_n_cap;
    logic               w_row_err;
    logic               w_out_free;
    logic               w_fire;
    logic               w_last_col;
    mme_pkg::t_mac_ctrl w_ctrl;
    logic signed [ELEM_W-1:0] w_rd_a, w_rd_b;
    logic               w_mac_done;
    logic signed [mme_pkg::DATA_W-1:0] w_mac_value;
    logic               w_mac_sat;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_W'(16);
            r_inner_dim <= DIM_W'(16);
            r_cols_b    <= DIM_W'(16);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mme_pkg::CFG_ROWS_A) begin
                r_rows_a <= i_cfg_data;
            end
            if (i_cfg_index == mme_pkg::CFG_INNER_DIM) begin
                r_inner_dim <= i_cfg_data;
            end
            if (i_cfg_index == mme_pkg::CFG_COLS_B) begin
                r_cols_b <= i_cfg_data;
            end
        end
    end

    // zero acts as one, anything above the store size as the store size
    assign w_m = (r_rows_a == '0) ? DIM_W'(1) :
                 ((int'(r_rows_a) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_rows_a);
    assign w_l = (r_inner_dim == '0) ? DIM_W'(1) :
                 ((int'(r_inner_dim) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_inner_dim);
    assign w_n = (r_cols_b == '0) ? DIM_W'(1) :
                 ((int'(r_cols_b) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_cols_b);
    assign w_n_cap = (int'(w_n) > mme_pkg::MAX_RESULTS) ?
                     DIM_W'(mme_pkg::MAX_RESULTS) : w_n;

    // ---------------- input side ----------------
    assign o_in_ready    = (r_state == ST_IDLE);
    assign w_in_accept   = i_in_valid && o_in_ready;
    assign w_is_load     = (i_in_item.operation == mme_pkg::OP_LOAD_A) ||
                           (i_in_item.operation == mme_pkg::OP_LOAD_B);
    assign w_ld_in_range = (int'(i_in_item.row_index) < MAX_DIM) &&
                           (int'(i_in_item.col_index) < MAX_DIM);
    assign w_wr_en       = w_in_accept && w_is_load && w_ld_in_range;
    assign w_ld_addr     = ADDR_W'(int'(i_in_item.row_index) * MAX_DIM +
                                   int'(i_in_item.col_index));
    assign w_row_err     = {1'b0, i_in_item.row_index} >= w_m;

    // ---------------- element memories ----------------
    mme_store #(
        .MAX_DIM (MAX_DIM),
        .ELEM_W  (ELEM_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_sel_b  (i_in_item.operation == mme_pkg::OP_LOAD_B),
        .i_wr_addr   (w_ld_addr),
        .i_wr_data   (i_in_item.element_value[ELEM_W-1:0]),
        .i_rd_addr_a (r_a_addr),
        .i_rd_addr_b (r_b_addr),
        .o_rd_data_a (w_rd_a),
        .o_rd_data_b (w_rd_b)
    );

    // ---------------- multiply-accumulate ----------------
    always_comb begin
        w_ctrl.valid = (r_state == ST_MAC);
        w_ctrl.first = (r_k == '0);
        w_ctrl.last  = (r_k == r_l_last);
    end

    mme_mac #(
        .ELEM_W (ELEM_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_a     (w_rd_a),
        .i_b     (w_rd_b),
        .i_take  (w_fire),
        .o_done  (w_mac_done),
        .o_value (w_mac_value),
        .o_sat   (w_mac_sat)
    );

    // ---------------- sequencer ----------------
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = (r_state == ST_EMIT) && (r_err || w_mac_done) && w_out_free;
    assign w_last_col = r_err || (r_j == r_n_last);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_j         = r_j;
        n_n_last    = r_n_last;
        n_k         = r_k;
        n_l_last    = r_l_last;
        n_a_base    = r_a_base;
        n_a_addr    = r_a_addr;
        n_b_addr    = r_b_addr;
        n_err       = r_err;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept && (i_in_item.operation == mme_pkg::OP_COMPUTE)) begin
                    n_row    = i_in_item.row_index;
                    n_err    = w_row_err;
                    n_j      = '0;
                    n_k      = '0;
                    n_l_last = w_l - DIM_W'(1);
                    n_n_last = COL_W'(w_n_cap - DIM_W'(1));
                    n_a_base = ADDR_W'(int'(i_in_item.row_index) * MAX_DIM);
                    n_a_addr = ADDR_W'(int'(i_in_item.row_index) * MAX_DIM);
                    n_b_addr = '0;
                    n_state  = w_row_err ? ST_EMIT : ST_MAC;
                end
            end
            ST_MAC: begin
                // one A and one B read per cycle along the inner dimension
                n_k      = r_k + DIM_W'(1);
                n_a_addr = r_a_addr + ADDR_W'(1);
                n_b_addr = r_b_addr + ADDR_W'(MAX_DIM);
                if (r_k == r_l_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_fire) begin
                    n_out_valid         = 1'b1;
                    n_out.out_row       = r_row;
                    n_out.out_col       = r_err ? '0 : r_j;
                    n_out.product_value = r_err ? '0 : w_mac_value;
                    n_out.saturated     = r_err ? 1'b0 : w_mac_sat;
                    n_out.row_error     = r_err;
                    n_out.last_of_row   = w_last_col;
                    if (w_last_col) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j      = r_j + COL_W'(1);
                        n_k      = '0;
                        n_a_addr = r_a_base;
                        n_b_addr = ADDR_W'(int'(r_j) + 1);
                        n_state  = ST_MAC;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_j      <= n_j;
        r_n_last <= n_n_last;
        r_k      <= n_k;
        r_l_last <= n_l_last;
        r_a_base <= n_a_base;
        r_a_addr <= n_a_addr;
        r_b_addr <= n_b_addr;
        r_err    <= n_err;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ---------------- assertions ----------------
    a_done_only_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_done |-> (r_state == ST_EMIT))
        else $error("finished sum outside of the emit state");

    a_idle_no_pending_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_mac_done)
        else $error("input taken while a sum is still pending");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_last_col) |=>
            ((r_state == ST_IDLE) && r_out_valid && r_out.last_of_row))
        else $error("last result of a row did not close the request");

    a_error_item_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.row_error) |->
            (r_out.last_of_row && (r_out.product_value == '0) && !r_out.saturated))
        else $error("row error item is malformed");

endmodule

`default_nettype wire

FILE: tb/sv/matrix_multiply_engine_top_tb.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top_tb: self-checking bench for the matrix engine
// Loads A and B elements, requests product rows under several dimension
// settings and compares every streamed element against a Q16.16 row model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_multiply_engine_top_tb;

    localparam logic [1:0]                    OP_UNUSED      = 2'd3;
    localparam logic [mme_pkg::CFG_IDX_W-1:0] CFG_SPARE_LOW  = 8'd3;
    localparam logic [mme_pkg::CFG_IDX_W-1:0] CFG_SPARE_HIGH = 8'hFF;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 10;
    localparam int TAIL_CYCLES  = 40;
    localparam int IDLE_PCT     = 27;

    localparam logic signed [71:0] FIX_MAX = 72'sd2147483647;
    localparam logic signed [71:0] FIX_MIN = -72'sd2147483648;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    mme_pkg::t_in_item    i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    mme_pkg::t_out_item   o_out_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [mme_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [mme_pkg::DIM_W-1:0]     i_cfg_data;

    // mirror of the engine state
    logic signed [mme_pkg::DATA_W-1:0] a_elems [256];
    logic signed [mme_pkg::DATA_W-1:0] b_elems [256];
    bit                                a_written [256];
    bit                                b_written [256];
    logic [mme_pkg::DIM_W-1:0]         rows_a_reg  = 5'd16;
    logic [mme_pkg::DIM_W-1:0]         inner_reg   = 5'd16;
    logic [mme_pkg::DIM_W-1:0]         cols_b_reg  = 5'd16;

    mme_pkg::t_out_item expected_products [$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    bit        no_gaps        = 1'b0;
    int        hold_cycles    = 0;

    matrix_multiply_engine_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int eff_dim(input logic [mme_pkg::DIM_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > mme_pkg::MAX_DIM_DEF) return mme_pkg::MAX_DIM_DEF;
        return int'(raw);
    endfunction

    function automatic mme_pkg::t_in_item make_item(input logic [1:0] op,
                                                    input logic [3:0] row,
                                                    input logic [3:0] col,
                                                    input logic [31:0] value);
        mme_pkg::t_in_item it;
        it.operation     = op;
        it.row_index     = row;
        it.col_index     = col;
        it.element_value = value;
        return it;
    endfunction

    function automatic logic [31:0] rand_element();
        int pick;
        pick = $urandom_range(19);
        case (pick)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            5, 6, 7, 8, 9, 10, 11: return 32'($urandom_range(262143)) - 32'd131072;
            default: return 32'($urandom);
        endcase
    endfunction

    // loads update the mirror; a row of C is the exact sum of Q32.32 products, rounded half up, clamped to Q16.16
    function automatic void predict_products(input mme_pkg::t_in_item it);
        int m, l, n;
        logic signed [71:0] acc;
        logic signed [71:0] rounded;
        mme_pkg::t_out_item res;
        case (it.operation)
            mme_pkg::OP_LOAD_A: begin
                a_elems[{it.row_index, it.col_index}]   = it.element_value;
                a_written[{it.row_index, it.col_index}] = 1'b1;
            end
            mme_pkg::OP_LOAD_B: begin
                b_elems[{it.row_index, it.col_index}]   = it.element_value;
                b_written[{it.row_index, it.col_index}] = 1'b1;
            end
            mme_pkg::OP_COMPUTE: begin
                m = eff_dim(rows_a_reg);
                l = eff_dim(inner_reg);
                n = eff_dim(cols_b_reg);
                if (it.row_index >= m) begin
                    res               = '0;
                    res.out_row       = it.row_index;
                    res.row_error     = 1'b1;
                    res.last_of_row   = 1'b1;
                    expected_products.push_back(res);
                end else begin
                    for (int j = 0; j < n; j++) begin
                        acc = '0;
                        for (int k = 0; k < l; k++)
                            acc = acc + a_elems[{it.row_index, 4'(k)}] * b_elems[{4'(k), 4'(j)}];
                        rounded = (acc + 72'sd32768) >>> 16;
                        res.out_row     = it.row_index;
                        res.out_col     = 4'(j);
                        res.row_error   = 1'b0;
                        res.last_of_row = (j == n - 1);
                        res.saturated   = (rounded > FIX_MAX) || (rounded < FIX_MIN);
                        if (rounded > FIX_MAX)
                            res.product_value = 32'h7FFF_FFFF;
                        else if (rounded < FIX_MIN)
                            res.product_value = 32'h8000_0000;
                        else
                            res.product_value = rounded[31:0];
                        expected_products.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        mme_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_products.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual %h", $time, o_out_item);
            end else begin
                want = expected_products.pop_front();
                check_field("out_row",       want.out_row,       o_out_item.out_row);
                check_field("out_col",       want.out_col,       o_out_item.out_col);
                check_field("product_value", want.product_value, o_out_item.product_value);
                check_field("saturated",     want.saturated,     o_out_item.saturated);
                check_field("row_error",     want.row_error,     o_out_item.row_error);
                check_field("last_of_row",   want.last_of_row,   o_out_item.last_of_row);
            end
        end
    end

    // result side: random stalls, a stall-free mode and long hold-offs on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else if (no_gaps) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
            @(negedge i_clk);
        end
    end

    // entered and left at a falling edge; valid stays high into the next item
    task automatic send_item(input mme_pkg::t_in_item it);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_products(it);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_products.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [mme_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mme_pkg::DIM_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mme_pkg::CFG_ROWS_A:    rows_a_reg = val;
            mme_pkg::CFG_INNER_DIM: inner_reg  = val;
            mme_pkg::CFG_COLS_B:    cols_b_reg = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_dims(input logic [mme_pkg::DIM_W-1:0] rows,
                            input logic [mme_pkg::DIM_W-1:0] inner,
                            input logic [mme_pkg::DIM_W-1:0] cols);
        wait_idle();
        cfg_write(mme_pkg::CFG_ROWS_A, rows);
        cfg_write(mme_pkg::CFG_INNER_DIM, inner);
        cfg_write(mme_pkg::CFG_COLS_B, cols);
        i_cfg_valid <= 1'b0;
    endtask

    // loads whatever operands of row r are still unwritten, then asks for the row
    task automatic run_row(input logic [3:0] r);
        int l, n;
        l = eff_dim(inner_reg);
        n = eff_dim(cols_b_reg);
        for (int k = 0; k < l; k++)
            if (!a_written[{r, 4'(k)}])
                send_item(make_item(mme_pkg::OP_LOAD_A, r, 4'(k), rand_element()));
        for (int k = 0; k < l; k++)
            for (int j = 0; j < n; j++)
                if (!b_written[{4'(k), 4'(j)}])
                    send_item(make_item(mme_pkg::OP_LOAD_B, 4'(k), 4'(j), rand_element()));
        send_item(make_item(mme_pkg::OP_COMPUTE, r, 4'($urandom), 32'($urandom)));
    endtask

    task automatic test_directed_cases();
        set_dims(5'd2, 5'd2, 5'd2);
        // largest operands: one column clamps high, the other low
        send_item(make_item(mme_pkg::OP_LOAD_A, 4'd0, 4'd0, 32'h7FFF_FFFF));
        send_item(make_item(mme_pkg::OP_LOAD_A, 4'd0, 4'd1, 32'h7FFF_FFFF));
        send_item(make_item(mme_pkg::OP_LOAD_B, 4'd0, 4'd0, 32'h7FFF_FFFF));
        send_item(make_item(mme_pkg::OP_LOAD_B, 4'd1, 4'd0, 32'h7FFF_FFFF));
        send_item(make_item(mme_pkg::OP_LOAD_B, 4'd0, 4'd1, 32'h8000_0000));
        send_item(make_item(mme_pkg::OP_LOAD_B, 4'd1, 4'd1, 32'h8000_0000));
        send_item(make_item(mme_pkg::OP_COMPUTE, 4'd0, 4'd0, 32'h0000_0000));
        // half-lsb ties, positive and negative, both round up
        send_item(make_item(mme_pkg::OP_LOAD_A, 4'd1, 4'd0, 32'h0000_0001));
        send_item(make_item(mme_pkg::OP_LOAD_A, 4'd1, 4'd1, 32'hFFFF_FFFF));
        send_item(make_item(mme_pkg::OP_LOAD_B, 4'd0, 4'd0, 32'h0000_8000));
        send_item(make_item(mme_pkg::OP_LOAD_B, 4'd1, 4'd0, 32'h0000_0000));
        send_item(make_item(mme_pkg::OP_LOAD_B, 4'd0, 4'd1, 32'h0000_0000));
        send_item(make_item(mme_pkg::OP_LOAD_B, 4'd1, 4'd1, 32'h0000_8000));
        send_item(make_item(mme_pkg::OP_COMPUTE, 4'd1, 4'd15, 32'hFFFF_FFFF));
        // unused operation, then rows at and past rows_a
        send_item(make_item(OP_UNUSED, 4'd15, 4'd15, 32'hFFFF_FFFF));
        send_item(make_item(mme_pkg::OP_COMPUTE, 4'd2, 4'd15, 32'hFFFF_FFFF));
        send_item(make_item(mme_pkg::OP_COMPUTE, 4'd15, 4'd0, 32'h0000_0000));
        send_item(make_item(mme_pkg::OP_LOAD_A, 4'd15, 4'd15, 32'h5555_5555));
        // exact range ends come out unclamped
        send_item(make_item(mme_pkg::OP_LOAD_A, 4'd0, 4'd0, 32'h0001_0000));
        send_item(make_item(mme_pkg::OP_LOAD_A, 4'd0, 4'd1, 32'h0000_0000));
        send_item(make_item(mme_pkg::OP_LOAD_B, 4'd0, 4'd0, 32'h7FFF_FFFF));
        send_item(make_item(mme_pkg::OP_LOAD_B, 4'd0, 4'd1, 32'h8000_0000));
        send_item(make_item(mme_pkg::OP_COMPUTE, 4'd0, 4'd5, 32'h1234_5678));
    endtask

    task automatic test_config_extremes();
        // zero acts as one, values past the maximum act as the maximum
        set_dims(5'd0, 5'd31, 5'd1);
        run_row(4'd0);
        send_item(make_item(mme_pkg::OP_COMPUTE, 4'd1, 4'd3, 32'h0));
        send_item(make_item(mme_pkg::OP_COMPUTE, 4'd15, 4'd3, 32'h0));
        set_dims(5'd31, 5'd0, 5'd31);
        run_row(4'd15);
        run_row(4'd0);
        // writes to unassigned indexes leave the sizes alone
        wait_idle();
        cfg_write(CFG_SPARE_HIGH, 5'h1F);
        cfg_write(CFG_SPARE_LOW, 5'h00);
        i_cfg_valid <= 1'b0;
        run_row(4'd7);
    endtask

    task automatic test_backpressure();
        set_dims(5'd4, 5'd4, 5'd4);
        for (int r = 0; r < 4; r++)
            run_row(4'(r));
        wait_idle();
        hold_cycles = 400;
        repeat (16) run_row(4'($urandom_range(3)));
        // let everything come back before offering more
        wait_idle();
        run_row(4'd3);
        send_item(make_item(mme_pkg::OP_COMPUTE, 4'd9, 4'($urandom), 32'($urandom)));
    endtask

    task automatic test_random_phases();
        int shapes [8][3] = '{'{3, 3, 3}, '{1, 1, 1}, '{17, 2, 5}, '{5, 16, 2},
                              '{2, 3, 16}, '{7, 5, 4}, '{16, 1, 1}, '{16, 16, 16}};
        int rows, inner, cols, pick, rounds;
        logic [3:0] r, c;
        logic [1:0] op;
        for (int p = 0; p < 8; p++) begin
            set_dims(5'(shapes[p][0]), 5'(shapes[p][1]), 5'(shapes[p][2]));
            rows   = eff_dim(rows_a_reg);
            inner  = eff_dim(inner_reg);
            cols   = eff_dim(cols_b_reg);
            no_gaps = (p == 2);
            rounds = (p == 7) ? 2 : ((p == 2) ? 30 : 8);
            repeat (rounds) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    send_item(make_item(OP_UNUSED, 4'($urandom), 4'($urandom), 32'($urandom)));
                end else if (pick < 14 && rows < 16) begin
                    send_item(make_item(mme_pkg::OP_COMPUTE, 4'($urandom_range(15, rows)),
                                        4'($urandom), 32'($urandom)));
                end else if (pick < 50) begin
                    run_row(4'($urandom_range(rows - 1)));
                end else begin
                    if ($urandom_range(99) < 70) begin
                        // overwrite an element that the current sizes actually use
                        if ($urandom_range(1)) begin
                            op = mme_pkg::OP_LOAD_A;
                            r  = 4'($urandom_range(rows - 1));
                            c  = 4'($urandom_range(inner - 1));
                        end else begin
                            op = mme_pkg::OP_LOAD_B;
                            r  = 4'($urandom_range(inner - 1));
                            c  = 4'($urandom_range(cols - 1));
                        end
                    end else begin
                        op = $urandom_range(1) ? mme_pkg::OP_LOAD_B : mme_pkg::OP_LOAD_A;
                        r  = 4'($urandom);
                        c  = 4'($urandom);
                    end
                    send_item(make_item(op, r, c, rand_element()));
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_config_extremes();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_products.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
